[sv/mpdf_pkg.sv]
// Package for the mesh packet duplicate suppression block.
// Table sizing, packet type codes, register indexes, reset values and types.
// No dependencies.
package mpdf_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam logic CMD_PACKET = 1'b0;
	localparam logic CMD_SWEEP  = 1'b1;

	localparam logic [7:0] TYPE_HEARTBEAT = 8'd7;
	localparam logic [7:0] TYPE_UNI_STR   = 8'd8;
	localparam logic [7:0] TYPE_UNI_NUM   = 8'd9;
	localparam logic [7:0] TYPE_BC_STR    = 8'd10;
	localparam logic [7:0] TYPE_BC_NUM    = 8'd11;

	localparam logic [1:0] DELIVER_NONE = 2'd0;
	localparam logic [1:0] DELIVER_STR  = 2'd1;
	localparam logic [1:0] DELIVER_NUM  = 2'd2;

	localparam logic [8:0] LEN_HEARTBEAT = 9'd11;
	localparam logic [8:0] LEN_STR_BASE  = 9'd12;
	localparam logic [8:0] LEN_NUMBER    = 9'd15;

	localparam logic [1:0] REG_OWN_ADDRESS     = 2'd0;
	localparam logic [1:0] REG_MAX_HOPS        = 2'd1;
	localparam logic [1:0] REG_REBOUND_PERCENT = 2'd2;
	localparam logic [1:0] REG_KEEP_TIME_MS    = 2'd3;

	localparam logic [31:0] RST_OWN_ADDRESS     = 32'd0;
	localparam logic [7:0]  RST_MAX_HOPS        = 8'd1;
	localparam logic [6:0]  RST_REBOUND_PERCENT = 7'd90;
	localparam logic [31:0] RST_KEEP_TIME_MS    = 32'd7000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic [31:0] address;
		logic [31:0] last_seen;
		logic [7:0]  last_id;
	} entry_t;

endpackage

[sv/mpdf_ifs.sv]
// Request and result channel interfaces for the mesh packet dedup block.
// Depends on nothing; payload widths are fixed by the packet header format.
interface mpdf_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] now_ms;
	logic [7:0]  pkt_type;
	logic [7:0]  message_id;
	logic [31:0] orig_address;
	logic [31:0] dest_address;
	logic [7:0]  hop_count;
	logic [7:0]  string_length;
	logic [6:0]  rand_percent;

	modport source (output valid, command, now_ms, pkt_type, message_id, orig_address,
		dest_address, hop_count, string_length, rand_percent, input ready);
	modport sink (input valid, command, now_ms, pkt_type, message_id, orig_address,
		dest_address, hop_count, string_length, rand_percent, output ready);
endinterface

interface mpdf_res_if;
	logic       valid;
	logic       ready;
	logic       dropped_own;
	logic       duplicate;
	logic [1:0] deliver;
	logic       forward;
	logic [7:0] forward_hops;
	logic [8:0] forward_length;
	logic       table_full;
	logic [4:0] member_count;

	modport source (output valid, dropped_own, duplicate, deliver, forward, forward_hops,
		forward_length, table_full, member_count, input ready);
	modport sink (input valid, dropped_own, duplicate, deliver, forward, forward_hops,
		forward_length, table_full, member_count, output ready);
endinterface

[sv/mesh_packet_dedup_forward.sv]
// Mesh packet duplicate suppression and forwarding decision, top level.
// Depends on mpdf_pkg and the channel interfaces in mpdf_ifs.sv.
// Own-address packets skip the table scan and go straight to the update state; others first
// scan the sender table memory one entry per cycle, through a read register and a check stage.
// A new request is taken only when idle, once the result of the last one has been loaded.
// Reset: registers to defaults, all sender entries invalid; no clearing pass needed.
module mesh_packet_dedup_forward
	import mpdf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	mpdf_req_if.sink    req,
	mpdf_res_if.source  res
);

	logic [31:0] own_address_q;
	logic [7:0]  max_hops_q;
	logic [6:0]  rebound_percent_q;
	logic [31:0] keep_time_ms_q;

	state_t state_q, state_d;

	logic        command_q;
	logic [31:0] now_ms_q;
	logic [7:0]  pkt_type_q;
	logic [7:0]  message_id_q;
	logic [31:0] orig_address_q;
	logic [31:0] dest_address_q;
	logic [7:0]  hop_count_q;
	logic [7:0]  string_length_q;
	logic [6:0]  rand_percent_q;

	entry_t mem [TABLE_DEPTH];
	entry_t rd_s1;
	logic             chk_v_s1;
	logic [IDX_W-1:0] chk_idx_s1;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       scan_cnt_q;

	logic             hit_found_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [7:0]       hit_id_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;

	logic       res_valid_q;
	logic       dropped_own_q;
	logic       duplicate_q;
	logic [1:0] deliver_q;
	logic       forward_q;
	logic [7:0] forward_hops_q;
	logic [8:0] forward_length_q;
	logic       table_full_q;
	logic [4:0] member_count_q;

	logic req_fire, issue, scan_done, res_load;
	logic chk_valid_entry, chk_hit, chk_free, chk_expire;
	logic is_own, newer, dup, ins, full, handle, try_fwd, fwd;
	logic [1:0]  deliver_d;
	logic [8:0]  flen_d;
	logic [31:0] expire_sum;
	logic [CNT_W+4:0] count_ext;
	logic [CNT_W-1:0] count_after;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign issue     = (state_q == ST_SCAN) && (scan_cnt_q < CNT_W'(TABLE_DEPTH));
	assign scan_done = !issue && !chk_v_s1;

	// check stage
	assign chk_valid_entry = valid_q[chk_idx_s1];
	assign expire_sum      = rd_s1.last_seen + keep_time_ms_q;
	assign chk_hit    = chk_v_s1 && (command_q == CMD_PACKET) && chk_valid_entry &&
		!hit_found_q && (rd_s1.address == orig_address_q);
	assign chk_free   = chk_v_s1 && (command_q == CMD_PACKET) && !chk_valid_entry &&
		!free_found_q;
	assign chk_expire = chk_v_s1 && (command_q == CMD_SWEEP) && chk_valid_entry &&
		(expire_sum < now_ms_q);

	// decision
	assign is_own = (command_q == CMD_PACKET) && (orig_address_q == own_address_q);
	assign newer  = hit_found_q && (message_id_q > hit_id_q);
	assign dup    = (command_q == CMD_PACKET) && !is_own && hit_found_q && !newer;
	assign ins    = (command_q == CMD_PACKET) && !is_own && !hit_found_q && free_found_q;
	assign full   = (command_q == CMD_PACKET) && !is_own && !hit_found_q && !free_found_q;
	assign handle = (command_q == CMD_PACKET) && !is_own && !dup;
	assign fwd    = handle && try_fwd && (hop_count_q < max_hops_q) &&
		(rand_percent_q < rebound_percent_q);
	assign count_after = count_q + CNT_W'(ins);
	assign count_ext   = (CNT_W + 5)'(count_after);
	assign res_load    = (state_q == ST_UPDATE) && (!res_valid_q || res.ready);

	always_comb begin
		deliver_d = DELIVER_NONE;
		try_fwd   = 1'b0;
		case (pkt_type_q)
			TYPE_HEARTBEAT: try_fwd = 1'b1;
			TYPE_UNI_STR: begin
				if (dest_address_q == own_address_q) deliver_d = DELIVER_STR;
				else try_fwd = 1'b1;
			end
			TYPE_UNI_NUM: begin
				if (dest_address_q == own_address_q) deliver_d = DELIVER_NUM;
				else try_fwd = 1'b1;
			end
			TYPE_BC_STR: begin
				deliver_d = DELIVER_STR;
				try_fwd   = 1'b1;
			end
			TYPE_BC_NUM: begin
				deliver_d = DELIVER_NUM;
				try_fwd   = 1'b1;
			end
			default: ;
		endcase
		if (!handle) deliver_d = DELIVER_NONE;
		case (pkt_type_q)
			TYPE_HEARTBEAT:            flen_d = LEN_HEARTBEAT;
			TYPE_UNI_STR, TYPE_BC_STR: flen_d = LEN_STR_BASE + {1'b0, string_length_q};
			default:                   flen_d = LEN_NUMBER;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					if (req.command == CMD_PACKET && req.orig_address == own_address_q)
						state_d = ST_UPDATE;
					else
						state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (res_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q     <= RST_OWN_ADDRESS;
			max_hops_q        <= RST_MAX_HOPS;
			rebound_percent_q <= RST_REBOUND_PERCENT;
			keep_time_ms_q    <= RST_KEEP_TIME_MS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OWN_ADDRESS:     own_address_q     <= cfg_data;
				REG_MAX_HOPS:        max_hops_q        <= cfg_data[7:0];
				REG_REBOUND_PERCENT: rebound_percent_q <= cfg_data[6:0];
				REG_KEEP_TIME_MS:    keep_time_ms_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			command_q       <= req.command;
			now_ms_q        <= req.now_ms;
			pkt_type_q      <= req.pkt_type;
			message_id_q    <= req.message_id;
			orig_address_q  <= req.orig_address;
			dest_address_q  <= req.dest_address;
			hop_count_q     <= req.hop_count;
			string_length_q <= req.string_length;
			rand_percent_q  <= req.rand_percent;
		end
	end

	// sender table: one read port for the scan, one write port for the update
	always_ff @(posedge clk) begin
		if (issue) rd_s1 <= mem[scan_cnt_q[IDX_W-1:0]];
		if (res_load && ins)
			mem[free_idx_q] <= '{address: orig_address_q, last_seen: now_ms_q,
				last_id: message_id_q};
		else if (res_load && newer && !is_own && command_q == CMD_PACKET)
			mem[hit_idx_q] <= '{address: orig_address_q, last_seen: now_ms_q,
				last_id: message_id_q};
	end

	always_ff @(posedge clk) begin
		if (issue) chk_idx_s1 <= scan_cnt_q[IDX_W-1:0];
		if (chk_hit) begin
			hit_idx_q <= chk_idx_s1;
			hit_id_q  <= rd_s1.last_id;
		end
		if (chk_free) free_idx_q <= chk_idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_v_s1     <= 1'b0;
			scan_cnt_q   <= '0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			valid_q      <= '0;
			count_q      <= '0;
		end else begin
			chk_v_s1 <= issue;
			if (req_fire) begin
				scan_cnt_q   <= '0;
				hit_found_q  <= 1'b0;
				free_found_q <= 1'b0;
			end else if (issue) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			if (chk_hit) hit_found_q <= 1'b1;
			if (chk_free) free_found_q <= 1'b1;
			if (chk_expire) begin
				valid_q[chk_idx_s1] <= 1'b0;
				count_q             <= count_q - 1'b1;
			end
			if (res_load && ins) begin
				valid_q[free_idx_q] <= 1'b1;
				count_q             <= count_after;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			dropped_own_q    <= is_own;
			duplicate_q      <= dup;
			deliver_q        <= deliver_d;
			forward_q        <= fwd;
			forward_hops_q   <= fwd ? hop_count_q + 8'd1 : 8'd0;
			forward_length_q <= fwd ? flen_d : 9'd0;
			table_full_q     <= full;
			member_count_q   <= count_ext[4:0];
		end
	end

	assign res.valid          = res_valid_q;
	assign res.dropped_own    = dropped_own_q;
	assign res.duplicate      = duplicate_q;
	assign res.deliver        = deliver_q;
	assign res.forward        = forward_q;
	assign res.forward_hops   = forward_hops_q;
	assign res.forward_length = forward_length_q;
	assign res.table_full     = table_full_q;
	assign res.member_count   = member_count_q;

endmodule

[test/testbench.sv]
// Testbench for mesh_packet_dedup_forward: directed table, then random packet and sweep traffic.
// Depends on mpdf_pkg, the channel interfaces in mpdf_ifs.sv and the block's top level.
// Results are checked in order against given verdicts or a sender-table model in this file.
`timescale 1ns / 1ps

module testbench;
	import mpdf_pkg::*;

	typedef struct packed {
		logic        command;
		logic [31:0] now_ms;
		logic [7:0]  pkt_type;
		logic [7:0]  message_id;
		logic [31:0] orig_address;
		logic [31:0] dest_address;
		logic [7:0]  hop_count;
		logic [7:0]  string_length;
		logic [6:0]  rand_percent;
	} header_t;

	typedef struct packed {
		logic       dropped_own;
		logic       duplicate;
		logic [1:0] deliver;
		logic       forward;
		logic [7:0] forward_hops;
		logic [8:0] forward_length;
		logic       table_full;
		logic [4:0] member_count;
	} verdict_t;

	typedef struct {
		header_t  hdr;
		bit       typed;
		verdict_t want;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	mpdf_req_if req_ch();
	mpdf_res_if res_ch();

	mesh_packet_dedup_forward dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.res       (res_ch)
	);

	always #4 clk = ~clk;

	// model of the node: registers and sender table
	logic [31:0] cfg_own      = RST_OWN_ADDRESS;
	logic [7:0]  cfg_max_hops = RST_MAX_HOPS;
	logic [6:0]  cfg_pct      = RST_REBOUND_PERCENT;
	logic [31:0] cfg_keep     = RST_KEEP_TIME_MS;
	logic [31:0] tbl_addr [TABLE_DEPTH];
	logic [31:0] tbl_seen [TABLE_DEPTH];
	logic [7:0]  tbl_id [TABLE_DEPTH];
	bit          tbl_valid [TABLE_DEPTH] = '{default: 1'b0};

	verdict_t pending_verdicts [$];
	directed_row_t directed [$];
	int errors = 0;
	int sender_idle_pct = 0;
	int stall_pct = 0;

	// random traffic state
	logic [31:0] sender_pool [32];
	logic [7:0]  next_id [32];
	int          pool_size = 8;
	logic [31:0] clock_ms = 0;

	logic [7:0]  phase_hops [8] = '{8'd3, 8'd0, 8'd255, 8'd8, 8'd1, 8'd255, 8'd5, 8'd2};
	logic [6:0]  phase_pct [8] = '{7'd90, 7'd100, 7'd0, 7'd127, 7'd50, 7'd100, 7'd75, 7'd1};
	logic [31:0] phase_keep [8] = '{32'd7000, 32'd0, 32'hFFFF_FFFF, 32'd20000,
		32'd3000, 32'd7000, 32'd50000, 32'd1000};

	function automatic verdict_t dedup_decide(header_t h);
		verdict_t v;
		int i;
		int hit;
		int spare;
		int n;
		bit try_fwd;
		logic [31:0] expiry;
		v = '0;
		hit = -1;
		spare = -1;
		n = 0;
		try_fwd = 1'b0;
		if (h.command == CMD_SWEEP) begin
			for (i = 0; i < TABLE_DEPTH; i++) begin
				expiry = tbl_seen[i] + cfg_keep;
				if (tbl_valid[i] && expiry < h.now_ms)
					tbl_valid[i] = 1'b0;
			end
		end else if (h.orig_address == cfg_own) begin
			v.dropped_own = 1'b1;
		end else begin
			for (i = 0; i < TABLE_DEPTH; i++) begin
				if (tbl_valid[i]) begin
					if (hit < 0 && tbl_addr[i] == h.orig_address)
						hit = i;
				end else if (spare < 0) begin
					spare = i;
				end
			end
			if (hit < 0) begin
				if (spare >= 0) begin
					tbl_valid[spare] = 1'b1;
					tbl_addr[spare] = h.orig_address;
					tbl_seen[spare] = h.now_ms;
					tbl_id[spare] = h.message_id;
				end else begin
					v.table_full = 1'b1;
				end
			end else if (h.message_id > tbl_id[hit]) begin
				tbl_id[hit] = h.message_id;
				tbl_seen[hit] = h.now_ms;
			end else begin
				v.duplicate = 1'b1;
			end
			if (!v.duplicate) begin
				case (h.pkt_type)
					TYPE_HEARTBEAT: try_fwd = 1'b1;
					TYPE_UNI_STR: begin
						if (h.dest_address == cfg_own)
							v.deliver = DELIVER_STR;
						else
							try_fwd = 1'b1;
					end
					TYPE_UNI_NUM: begin
						if (h.dest_address == cfg_own)
							v.deliver = DELIVER_NUM;
						else
							try_fwd = 1'b1;
					end
					TYPE_BC_STR: begin
						v.deliver = DELIVER_STR;
						try_fwd = 1'b1;
					end
					TYPE_BC_NUM: begin
						v.deliver = DELIVER_NUM;
						try_fwd = 1'b1;
					end
					default: ;
				endcase
				if (try_fwd && h.hop_count < cfg_max_hops && h.rand_percent < cfg_pct) begin
					v.forward = 1'b1;
					v.forward_hops = h.hop_count + 8'd1;
					if (h.pkt_type == TYPE_HEARTBEAT)
						v.forward_length = LEN_HEARTBEAT;
					else if (h.pkt_type == TYPE_UNI_STR || h.pkt_type == TYPE_BC_STR)
						v.forward_length = LEN_STR_BASE + {1'b0, h.string_length};
					else
						v.forward_length = LEN_NUMBER;
				end
			end
		end
		for (i = 0; i < TABLE_DEPTH; i++)
			if (tbl_valid[i])
				n++;
		v.member_count = 5'(n);
		return v;
	endfunction

	function automatic header_t packet(logic [7:0] ty, logic [7:0] id, logic [31:0] orig,
		logic [31:0] dest, logic [7:0] hops, logic [7:0] slen, logic [6:0] rnd, logic [31:0] now);
		return {CMD_PACKET, now, ty, id, orig, dest, hops, slen, rnd};
	endfunction

	function automatic header_t sweep(logic [31:0] now);
		header_t s;
		s = '0;
		s.command = CMD_SWEEP;
		s.now_ms = now;
		return s;
	endfunction

	function automatic verdict_t verdict(logic drop, logic dup, logic [1:0] dl, logic fwd,
		logic [7:0] fh, logic [8:0] fl, logic full, logic [4:0] cnt);
		return {drop, dup, dl, fwd, fh, fl, full, cnt};
	endfunction

	function automatic void add_row(directed_row_t row);
		directed.insert(directed.size(), row);
	endfunction

	// mostly well-formed traffic from a small sender pool, with rising ids and time
	function automatic header_t random_header();
		header_t h;
		int slot;
		int roll;
		roll = $urandom_range(99);
		clock_ms = (roll < 3) ? 32'($urandom) : clock_ms + 32'($urandom_range(1500));
		slot = $urandom_range(pool_size - 1);
		h.command = (roll >= 3 && roll < 11) ? CMD_SWEEP : CMD_PACKET;
		h.now_ms = clock_ms;
		h.orig_address = ($urandom_range(99) < 5) ? cfg_own : sender_pool[slot];
		if ($urandom_range(99) < 75) begin
			next_id[slot] = next_id[slot] + 8'($urandom_range(3));
			h.message_id = next_id[slot];
		end else begin
			h.message_id = 8'($urandom);
		end
		h.pkt_type = ($urandom_range(99) < 85) ? TYPE_HEARTBEAT + 8'($urandom_range(4))
			: 8'($urandom);
		if ($urandom_range(99) < 40)
			h.dest_address = cfg_own;
		else
			h.dest_address = $urandom_range(1) ? sender_pool[$urandom_range(pool_size - 1)]
				: 32'($urandom);
		h.hop_count = ($urandom_range(99) < 80) ? 8'($urandom_range(10)) : 8'($urandom);
		h.string_length = 8'($urandom);
		h.rand_percent = 7'($urandom_range(99));
		return h;
	endfunction

	task automatic send_header(header_t h, bit typed, verdict_t want);
		int gap;
		verdict_t predicted;
		gap = 0;
		if ($urandom_range(99) < sender_idle_pct)
			gap = $urandom_range(1, 25);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.command <= h.command;
		req_ch.now_ms <= h.now_ms;
		req_ch.pkt_type <= h.pkt_type;
		req_ch.message_id <= h.message_id;
		req_ch.orig_address <= h.orig_address;
		req_ch.dest_address <= h.dest_address;
		req_ch.hop_count <= h.hop_count;
		req_ch.string_length <= h.string_length;
		req_ch.rand_percent <= h.rand_percent;
		req_ch.valid <= 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		predicted = dedup_decide(h);
		pending_verdicts.insert(pending_verdicts.size(), typed ? want : predicted);
	endtask

	task automatic wait_for_verdicts();
		req_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic program_node(logic [31:0] own, logic [7:0] hops, logic [6:0] pct,
		logic [31:0] keep);
		logic [31:0] junk;
		junk = $urandom;
		write_reg(REG_OWN_ADDRESS, own);
		write_reg(REG_MAX_HOPS, {junk[31:8], hops});
		write_reg(REG_REBOUND_PERCENT, {junk[31:7], pct});
		write_reg(REG_KEEP_TIME_MS, keep);
		cfg_we <= 1'b0;
		cfg_own = own;
		cfg_max_hops = hops;
		cfg_pct = pct;
		cfg_keep = keep;
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk)
		res_ch.ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		verdict_t got;
		verdict_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = {res_ch.dropped_own, res_ch.duplicate, res_ch.deliver, res_ch.forward,
				res_ch.forward_hops, res_ch.forward_length, res_ch.table_full,
				res_ch.member_count};
			if (pending_verdicts.size() == 0) begin
				errors++;
				$display("%0t ns: result with no request outstanding, actual %h", $time, got);
			end else begin
				want = pending_verdicts.pop_front();
				check_field("dropped_own", 32'(want.dropped_own), 32'(got.dropped_own));
				check_field("duplicate", 32'(want.duplicate), 32'(got.duplicate));
				check_field("deliver", 32'(want.deliver), 32'(got.deliver));
				check_field("forward", 32'(want.forward), 32'(got.forward));
				check_field("forward_hops", 32'(want.forward_hops), 32'(got.forward_hops));
				check_field("forward_length", 32'(want.forward_length),
					32'(got.forward_length));
				check_field("table_full", 32'(want.table_full), 32'(got.table_full));
				check_field("member_count", 32'(want.member_count), 32'(got.member_count));
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		int k;
		int phase;
		logic [31:0] own;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_OWN_ADDRESS;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_PACKET;
		req_ch.now_ms = '0;
		req_ch.pkt_type = '0;
		req_ch.message_id = '0;
		req_ch.orig_address = '0;
		req_ch.dest_address = '0;
		req_ch.hop_count = '0;
		req_ch.string_length = '0;
		req_ch.rand_percent = '0;

		// reset settings: own address 0, one hop, 90 percent
		add_row('{packet(TYPE_HEARTBEAT, 8'd1, 32'h0, 32'h0, 8'd0, 8'd0, 7'd0, 32'd0),
			1'b1, verdict(1, 0, DELIVER_NONE, 0, 8'd0, 9'd0, 0, 5'd0)});
		add_row('{packet(TYPE_HEARTBEAT, 8'd5, 32'hA1, 32'hFFFF_FFFF, 8'd0, 8'd0,
			7'd0, 32'd100), 1'b1, verdict(0, 0, DELIVER_NONE, 1, 8'd1, LEN_HEARTBEAT, 0, 5'd1)});
		add_row('{packet(TYPE_HEARTBEAT, 8'd5, 32'hA1, 32'hFFFF_FFFF, 8'd0, 8'd0,
			7'd0, 32'd110), 1'b1, verdict(0, 1, DELIVER_NONE, 0, 8'd0, 9'd0, 0, 5'd1)});
		add_row('{packet(TYPE_HEARTBEAT, 8'd4, 32'hA1, 32'hFFFF_FFFF, 8'd0, 8'd0,
			7'd0, 32'd120), 1'b1, verdict(0, 1, DELIVER_NONE, 0, 8'd0, 9'd0, 0, 5'd1)});
		add_row('{packet(TYPE_UNI_STR, 8'd6, 32'hA1, 32'h0, 8'd0, 8'd40, 7'd0,
			32'd130), 1'b1, verdict(0, 0, DELIVER_STR, 0, 8'd0, 9'd0, 0, 5'd1)});
		add_row('{packet(TYPE_UNI_STR, 8'd1, 32'hB2, 32'hFFFF_FFFF, 8'd0, 8'd255,
			7'd89, 32'd140), 1'b1, verdict(0, 0, DELIVER_NONE, 1, 8'd1, 9'd267, 0, 5'd2)});
		add_row('{packet(TYPE_UNI_NUM, 8'd1, 32'hC3, 32'h0, 8'd0, 8'd0, 7'd0,
			32'd150), 1'b1, verdict(0, 0, DELIVER_NUM, 0, 8'd0, 9'd0, 0, 5'd3)});
		add_row('{packet(TYPE_UNI_NUM, 8'd1, 32'hD4, 32'h5, 8'd0, 8'd0, 7'd99,
			32'd160), 1'b1, verdict(0, 0, DELIVER_NONE, 0, 8'd0, 9'd0, 0, 5'd4)});
		add_row('{packet(TYPE_BC_STR, 8'd1, 32'hE5, 32'h5, 8'd1, 8'd7, 7'd0,
			32'd170), 1'b1, verdict(0, 0, DELIVER_STR, 0, 8'd0, 9'd0, 0, 5'd5)});
		add_row('{packet(TYPE_BC_NUM, 8'd1, 32'hF6, 32'h5, 8'd0, 8'd0, 7'd50,
			32'd180), 1'b1, verdict(0, 0, DELIVER_NUM, 1, 8'd1, LEN_NUMBER, 0, 5'd6)});
		add_row('{packet(8'd0, 8'd1, 32'h17, 32'h5, 8'd0, 8'd0, 7'd0, 32'd185),
			1'b1, verdict(0, 0, DELIVER_NONE, 0, 8'd0, 9'd0, 0, 5'd7)});
		add_row('{packet(8'd255, 8'd1, 32'h28, 32'h5, 8'd0, 8'd0, 7'd0, 32'd190),
			1'b1, verdict(0, 0, DELIVER_NONE, 0, 8'd0, 9'd0, 0, 5'd8)});
		add_row('{packet(TYPE_HEARTBEAT, 8'd255, 32'hA1, 32'h5, 8'd0, 8'd0, 7'd10,
			32'd200), 1'b1, verdict(0, 0, DELIVER_NONE, 1, 8'd1, LEN_HEARTBEAT, 0, 5'd8)});
		// id does not wrap: 0 after 255 is a duplicate
		add_row('{packet(TYPE_HEARTBEAT, 8'd0, 32'hA1, 32'h5, 8'd0, 8'd0, 7'd10,
			32'd210), 1'b1, verdict(0, 1, DELIVER_NONE, 0, 8'd0, 9'd0, 0, 5'd8)});
		for (k = 0; k < 8; k++)
			add_row('{packet(TYPE_HEARTBEAT + 8'(k % 5), 8'(k * 37), 32'h100 + k,
				32'(k) * 32'h2222_2222, (k == 0) ? 8'd255 : 8'(k % 2), 8'(k * 36),
				7'(k * 14), 32'd300 + k), 1'b0, '0});
		// table full: sender not stored, packet still handled
		add_row('{packet(TYPE_BC_STR, 8'hAA, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0,
			8'h55, 7'd3, 32'hFFFF_FFFE), 1'b0, '0});
		add_row('{sweep(32'hFFFF_FFFF), 1'b1,
			verdict(0, 0, DELIVER_NONE, 0, 8'd0, 9'd0, 0, 5'd0)});
		add_row('{sweep(32'h0), 1'b1,
			verdict(0, 0, DELIVER_NONE, 0, 8'd0, 9'd0, 0, 5'd0)});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[r])
			send_header(directed[r].hdr, directed[r].typed, directed[r].want);
		wait_for_verdicts();

		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin sender_idle_pct = 0; stall_pct = 0; end
				1: begin sender_idle_pct = 70; stall_pct = 0; end
				2: begin sender_idle_pct = 0; stall_pct = 70; end
				default: begin sender_idle_pct = 13; stall_pct = 13; end
			endcase
			if (phase == 1)
				own = 32'hFFFF_FFFF;
			else if (phase == 2)
				own = 32'h0;
			else
				own = $urandom;
			program_node(own, phase_hops[phase], phase_pct[phase], phase_keep[phase]);
			pool_size = $urandom_range(6, 30);
			for (k = 0; k < pool_size; k++) begin
				sender_pool[k] = $urandom;
				next_id[k] = 8'($urandom);
			end
			clock_ms = $urandom_range(100000);
			repeat (172)
				send_header(random_header(), 1'b0, '0);
			wait_for_verdicts();
		end

		repeat (25) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
